// ----- rtl/rdft7_pkg.sv -----
`default_nettype none

package rdft7_pkg;

   // sample and coefficient formats
   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int OUT_WIDTH      = SAMPLE_WIDTH + 4;

   // weight magnitude holds up to 2.0 in COEF_FRAC_BITS fraction bits
   localparam int MAG_WIDTH  = COEF_FRAC_BITS + 2;
   // one product, and a sum of seven products
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_FRAC_BITS + 2;
   localparam int SUM_WIDTH  = PROD_WIDTH + 3;

   localparam int NUM_PTS = 7;

   // configuration port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_INVERSE_MODE = 1'b0;

   // weight codes: sign is the sign of the weight
   localparam logic [3:0] CODE_NONE = 4'd0;
   localparam logic [3:0] CODE_UNIT = 4'd1;
   localparam logic [3:0] CODE_TWO  = 4'd8;
   localparam logic [3:0] CODE_FIRST_COEF = 4'd2;
   localparam logic [3:0] CODE_LAST_COEF  = 4'd7;

   // |cos 6pi/7|, sin 6pi/7, cos 2pi/7, sin 2pi/7, |cos 4pi/7|, sin 4pi/7 in q32
   localparam logic [63:0] COEF_Q32 [6] = '{
      64'd3869631822, 64'd1863516470, 64'd2677868308,
      64'd3357940648, 64'd955720134,  64'd4187283499
   };

   // weight code per mode (forward, inverse), output row, input column
   localparam logic signed [4:0] WEIGHT_CODE [2][NUM_PTS][NUM_PTS] = '{
      '{
         '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
         '{ 5'sd1,  5'sd4, -5'sd6, -5'sd2, -5'sd2, -5'sd6,  5'sd4},
         '{ 5'sd0, -5'sd5, -5'sd7, -5'sd3,  5'sd3,  5'sd7,  5'sd5},
         '{ 5'sd1, -5'sd6, -5'sd2,  5'sd4,  5'sd4, -5'sd2, -5'sd6},
         '{ 5'sd0, -5'sd7,  5'sd3,  5'sd5, -5'sd5, -5'sd3,  5'sd7},
         '{ 5'sd1, -5'sd2,  5'sd4, -5'sd6, -5'sd6,  5'sd4, -5'sd2},
         '{ 5'sd0, -5'sd3,  5'sd5, -5'sd7,  5'sd7, -5'sd5,  5'sd3}
      },
      '{
         '{ 5'sd1,  5'sd8,  5'sd0,  5'sd8,  5'sd0,  5'sd8,  5'sd0},
         '{ 5'sd1,  5'sd4, -5'sd5, -5'sd6, -5'sd7, -5'sd2, -5'sd3},
         '{ 5'sd1, -5'sd6, -5'sd7, -5'sd2,  5'sd3,  5'sd4,  5'sd5},
         '{ 5'sd1, -5'sd2, -5'sd3,  5'sd4,  5'sd5, -5'sd6, -5'sd7},
         '{ 5'sd1, -5'sd2,  5'sd3,  5'sd4, -5'sd5, -5'sd6,  5'sd7},
         '{ 5'sd1, -5'sd6,  5'sd7, -5'sd2, -5'sd3,  5'sd4, -5'sd5},
         '{ 5'sd1,  5'sd4,  5'sd5, -5'sd6,  5'sd7, -5'sd2,  5'sd3}
      }
   };

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] x0;
      logic signed [SAMPLE_WIDTH-1:0] x1;
      logic signed [SAMPLE_WIDTH-1:0] x2;
      logic signed [SAMPLE_WIDTH-1:0] x3;
      logic signed [SAMPLE_WIDTH-1:0] x4;
      logic signed [SAMPLE_WIDTH-1:0] x5;
      logic signed [SAMPLE_WIDTH-1:0] x6;
      logic                           batch_last;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] y0;
      logic signed [OUT_WIDTH-1:0] y1;
      logic signed [OUT_WIDTH-1:0] y2;
      logic signed [OUT_WIDTH-1:0] y3;
      logic signed [OUT_WIDTH-1:0] y4;
      logic signed [OUT_WIDTH-1:0] y5;
      logic signed [OUT_WIDTH-1:0] y6;
      logic                        batch_end;
   } rsp_type;

   // per-stage load strobes from the pipeline control
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } stage_load_type;

   // weight magnitude: inverse constants carry one more fraction bit (doubled)
   function automatic logic [MAG_WIDTH-1:0] weight_mag(input logic [3:0] code,
                                                       input logic inv);
      logic [63:0] q;
      logic [63:0] r;
      int unsigned b;
      logic [2:0]  idx;
      r   = 64'd0;
      idx = 3'(code - CODE_FIRST_COEF);
      b   = inv ? COEF_FRAC_BITS + 1 : COEF_FRAC_BITS;
      q   = COEF_Q32[idx];
      if (code == CODE_UNIT) begin
         r = 64'd1 << COEF_FRAC_BITS;
      end else if (code == CODE_TWO) begin
         r = 64'd2 << COEF_FRAC_BITS;
      end else if (code >= CODE_FIRST_COEF && code <= CODE_LAST_COEF) begin
         r = (q + (64'd1 << (31 - b))) >> (32 - b);
      end
      return MAG_WIDTH'(r);
   endfunction

   function automatic logic [3:0] code_abs(input logic signed [4:0] code);
      logic [4:0] a;
      a = code[4] ? 5'(-code) : 5'(code);
      return a[3:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rdft7_datapath.sv -----
`default_nettype none

module rdft7_datapath
   import rdft7_pkg::*;
(
   input  wire logic           clock,
   input  wire stage_load_type load,
   input  wire logic           mode,
   input  wire req_type        req_payload,
   output rsp_type             rsp_payload
);

   localparam int HALF = 4;

   // stage 1: captured samples
   logic signed [SAMPLE_WIDTH-1:0] x_ff [NUM_PTS];
   logic                           mode_ff;
   logic                           last1_ff;

   // stage 2: signed weighted products
   logic signed [PROD_WIDTH-1:0] prod_ff [NUM_PTS][NUM_PTS];
   logic signed [PROD_WIDTH-1:0] prod_in [NUM_PTS][NUM_PTS];
   logic                         last2_ff;

   // stage 3: two partial sums per output
   logic signed [SUM_WIDTH-1:0] part_lo_ff [NUM_PTS];
   logic signed [SUM_WIDTH-1:0] part_hi_ff [NUM_PTS];
   logic signed [SUM_WIDTH-1:0] part_lo_in [NUM_PTS];
   logic signed [SUM_WIDTH-1:0] part_hi_in [NUM_PTS];
   logic                        last3_ff;

   // stage 4: rounded results
   logic signed [OUT_WIDTH-1:0] y_ff [NUM_PTS];
   logic signed [OUT_WIDTH-1:0] y_in [NUM_PTS];
   logic                        last4_ff;

   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
      SUM_WIDTH'(64'd1 << (COEF_FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (load.ld1) begin
         x_ff[0]  <= req_payload.x0;
         x_ff[1]  <= req_payload.x1;
         x_ff[2]  <= req_payload.x2;
         x_ff[3]  <= req_payload.x3;
         x_ff[4]  <= req_payload.x4;
         x_ff[5]  <= req_payload.x5;
         x_ff[6]  <= req_payload.x6;
         mode_ff  <= mode;
         last1_ff <= req_payload.batch_last;
      end
   end

   // one constant-weight multiply per row and column, sign folded into the sample
   always_comb begin
      logic signed [4:0]            code;
      logic signed [SAMPLE_WIDTH:0] a;
      logic signed [PROD_WIDTH-1:0] a_ext;
      logic signed [PROD_WIDTH-1:0] m_ext;
      for (int k = 0; k < NUM_PTS; k++) begin
         for (int j = 0; j < NUM_PTS; j++) begin
            code  = WEIGHT_CODE[mode_ff][k][j];
            a     = code[4] ? -(SAMPLE_WIDTH+1)'(x_ff[j]) : (SAMPLE_WIDTH+1)'(x_ff[j]);
            a_ext = PROD_WIDTH'(a);
            m_ext = signed'(PROD_WIDTH'(weight_mag(code_abs(code), mode_ff)));
            prod_in[k][j] = a_ext * m_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load.ld2) begin
         prod_ff  <= prod_in;
         last2_ff <= last1_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_PTS; k++) begin
         part_lo_in[k] = '0;
         part_hi_in[k] = '0;
         for (int j = 0; j < HALF; j++) begin
            part_lo_in[k] = part_lo_in[k] + SUM_WIDTH'(prod_ff[k][j]);
         end
         for (int j = HALF; j < NUM_PTS; j++) begin
            part_hi_in[k] = part_hi_in[k] + SUM_WIDTH'(prod_ff[k][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load.ld3) begin
         part_lo_ff <= part_lo_in;
         part_hi_ff <= part_hi_in;
         last3_ff   <= last2_ff;
      end
   end

   // round half up from COEF_FRAC_BITS fraction bits
   always_comb begin
      logic signed [SUM_WIDTH-1:0] total;
      for (int k = 0; k < NUM_PTS; k++) begin
         total   = part_lo_ff[k] + part_hi_ff[k] + ROUND_HALF;
         y_in[k] = total[COEF_FRAC_BITS+OUT_WIDTH-1:COEF_FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (load.ld4) begin
         y_ff     <= y_in;
         last4_ff <= last3_ff;
      end
   end

   assign rsp_payload.y0        = y_ff[0];
   assign rsp_payload.y1        = y_ff[1];
   assign rsp_payload.y2        = y_ff[2];
   assign rsp_payload.y3        = y_ff[3];
   assign rsp_payload.y4        = y_ff[4];
   assign rsp_payload.y5        = y_ff[5];
   assign rsp_payload.y6        = y_ff[6];
   assign rsp_payload.batch_end = last4_ff;

endmodule

`default_nettype wire

// ----- rtl/real_dft7_butterfly.sv -----
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-----------------------------
// req       | in        | req_valid / req_stall      | req_payload (x0..x6, batch_last)
// rsp       | out       | rsp_valid / rsp_stall      | rsp_payload (y0..y6, batch_end)
// csr       | in        | apb psel/penable/pready    | inverse_mode at byte address 0
//
// one transaction per cycle sustained while rsp_stall is low; four register stages
// (capture, multiply, partial sums, round) lie between the accepting edge and rsp_valid
// each stage holds while the stage after it is full and stalled; rsp_stall
// reaches req_stall through the ready chain only when every stage is full
// synchronous active-high reset clears the stage valid bits and inverse_mode
// inverse_mode is sampled with each transaction and held in the capture stage

`default_nettype none

module real_dft7_butterfly
   import rdft7_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_payload,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_payload,

   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                           csr_pready
);

   // register file: a single mode bit
   logic mode_ff;
   logic mode_in;
   logic csr_wr;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;

   // a stage can take new data when empty or when its content moves on
   logic rdy1, rdy2, rdy3, rdy4;

   stage_load_type load;

   // apb access phase write; the register index is the word address bit
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_INVERSE_MODE)
                       ? CSR_DATA_WIDTH'(mode_ff) : '0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && csr_paddr[2] == CSR_IDX_INVERSE_MODE) begin
         mode_in = csr_pwdata[0];
      end
   end

   // ready chain from the output back to the input
   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;
   assign rsp_valid = v4_ff;

   // a stage loads whenever it is free; its valid bit follows the stage before
   assign load.ld1 = rdy1;
   assign load.ld2 = rdy2;
   assign load.ld3 = rdy3;
   assign load.ld4 = rdy4;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff     : v2_ff;
   assign v3_in = rdy3 ? v2_ff     : v3_ff;
   assign v4_in = rdy4 ? v3_ff     : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         v4_ff   <= v4_in;
      end
   end

   // capture, multiply, partial sums and rounding
   rdft7_datapath u_datapath (
      .clock       (clock),
      .load        (load),
      .mode        (mode_ff),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   // input is held back only when the whole pipe is full
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("input stalled with a free pipeline stage");

   // a stage whose successor cannot take it keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy4) |=> v3_ff)
      else $error("stage 3 transaction dropped under stall");

   // a write to the mode register lands on the next edge
   assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == CSR_IDX_INVERSE_MODE) |=> mode_ff == $past(csr_pwdata[0]))
      else $error("inverse_mode write lost");

   // an emptied output stage with nothing behind it goes idle
   assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !rsp_stall && !v3_ff) |=> !v4_ff)
      else $error("result repeated after delivery");

endmodule

`default_nettype wire
